[sv/semwq_pkg.sv]
package semwq_pkg;

	localparam int NUM_SEMAPHORES_DEF = 3;
	localparam int QUEUE_DEPTH_DEF = 8;
	localparam int PID_W = 8;
	localparam int COUNT_W = 8;
	localparam logic [COUNT_W-1:0] COUNT_MAX = 8'hFF;
	localparam logic [COUNT_W-1:0] COUNT_RESET = 8'd1;

	typedef enum logic {
		CMD_WAIT = 1'b0,
		CMD_SIGNAL = 1'b1
	} cmd_t;

	typedef enum logic [2:0] {
		ST_ACQUIRED = 3'd0,
		ST_BLOCKED = 3'd1,
		ST_RELEASED = 3'd2,
		ST_WOKE = 3'd3,
		ST_INVALID = 3'd4,
		ST_FULL = 3'd5,
		ST_SATURATED = 3'd6
	} status_t;

	// outcome of one command as seen by the pipeline and the wait store
	typedef struct packed {
		status_t status;
		logic push;
		logic pop;
	} semwq_res_t;

endpackage

[sv/semwq_cmd_if.sv]
interface semwq_cmd_if;
	import semwq_pkg::*;

	logic valid;
	logic ready;
	logic command;
	logic [1:0] mutex_id;
	logic [PID_W-1:0] process_id;

	modport source (output valid, output command, output mutex_id, output process_id,
		input ready);
	modport sink (input valid, input command, input mutex_id, input process_id,
		output ready);

endinterface

[sv/semwq_rsp_if.sv]
interface semwq_rsp_if;
	import semwq_pkg::*;

	logic valid;
	logic ready;
	logic [2:0] status;
	logic [PID_W-1:0] woken_pid;

	modport source (output valid, output status, output woken_pid, input ready);
	modport sink (input valid, input status, input woken_pid, output ready);

endinterface

[sv/semwq_state.sv]
module semwq_state
	import semwq_pkg::*;
#(
	parameter int NUM_SEMAPHORES = NUM_SEMAPHORES_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
	localparam int SEM_W = (NUM_SEMAPHORES > 1) ? $clog2(NUM_SEMAPHORES) : 1,
	localparam int PTR_W = $clog2(QUEUE_DEPTH),
	localparam int FILL_W = $clog2(QUEUE_DEPTH + 1)
) (
	input logic clk,
	input logic arst_n,
	input logic commit,
	input logic command,
	input logic [1:0] mutex_id,
	input logic [1:0] look_id,
	output semwq_res_t res,
	output logic [SEM_W-1:0] wr_sem,
	output logic [PTR_W-1:0] wr_slot,
	output logic [SEM_W-1:0] look_sem,
	output logic [PTR_W-1:0] look_slot
);

	localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);

	logic [COUNT_W-1:0] cnt_q [NUM_SEMAPHORES];
	logic [PTR_W-1:0] head_q [NUM_SEMAPHORES];
	logic [PTR_W-1:0] tail_q [NUM_SEMAPHORES];
	logic [FILL_W-1:0] fill_q [NUM_SEMAPHORES];

	logic [COUNT_W-1:0] cnt_d [NUM_SEMAPHORES];
	logic [PTR_W-1:0] head_d [NUM_SEMAPHORES];
	logic [PTR_W-1:0] tail_d [NUM_SEMAPHORES];
	logic [FILL_W-1:0] fill_d [NUM_SEMAPHORES];

	logic id_ok;
	logic look_ok;
	logic [SEM_W-1:0] idx;
	logic [COUNT_W-1:0] cnt;
	logic [PTR_W-1:0] head;
	logic [PTR_W-1:0] tail;
	logic [FILL_W-1:0] fill;

	assign id_ok = int'(mutex_id) < NUM_SEMAPHORES;
	assign look_ok = int'(look_id) < NUM_SEMAPHORES;
	assign idx = id_ok ? mutex_id[SEM_W-1:0] : '0;
	assign look_sem = look_ok ? look_id[SEM_W-1:0] : '0;

	assign cnt = cnt_q[idx];
	assign head = head_q[idx];
	assign tail = tail_q[idx];
	assign fill = fill_q[idx];

	assign wr_sem = idx;
	assign wr_slot = tail;

	always_comb begin
		res.status = ST_INVALID;
		res.push = 1'b0;
		res.pop = 1'b0;
		cnt_d = cnt_q;
		head_d = head_q;
		tail_d = tail_q;
		fill_d = fill_q;
		if (id_ok) begin
			if (command == CMD_WAIT) begin
				if (cnt != '0) begin
					res.status = ST_ACQUIRED;
					if (commit) begin
						cnt_d[idx] = cnt - COUNT_W'(1);
					end
				end else if (fill == FILL_W'(QUEUE_DEPTH)) begin
					res.status = ST_FULL;
				end else begin
					res.status = ST_BLOCKED;
					res.push = 1'b1;
					if (commit) begin
						tail_d[idx] = (tail == LAST_SLOT) ? '0 : tail + PTR_W'(1);
						fill_d[idx] = fill + FILL_W'(1);
					end
				end
			end else begin
				if (fill != '0) begin
					res.status = ST_WOKE;
					res.pop = 1'b1;
					if (commit) begin
						head_d[idx] = (head == LAST_SLOT) ? '0 : head + PTR_W'(1);
						fill_d[idx] = fill - FILL_W'(1);
					end
				end else if (cnt == COUNT_MAX) begin
					res.status = ST_SATURATED;
				end else begin
					res.status = ST_RELEASED;
					if (commit) begin
						cnt_d[idx] = cnt + COUNT_W'(1);
					end
				end
			end
		end
	end

	// head as it stands after this cycle's commit, for the next word's lookup
	assign look_slot = head_d[look_sem];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < NUM_SEMAPHORES; s++) begin
				cnt_q[s] <= COUNT_RESET;
				head_q[s] <= '0;
				tail_q[s] <= '0;
				fill_q[s] <= '0;
			end
		end else begin
			cnt_q <= cnt_d;
			head_q <= head_d;
			tail_q <= tail_d;
			fill_q <= fill_d;
		end
	end

endmodule

[sv/semwq_store.sv]
module semwq_store
	import semwq_pkg::*;
#(
	parameter int NUM_SEMAPHORES = NUM_SEMAPHORES_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
	localparam int SEM_W = (NUM_SEMAPHORES > 1) ? $clog2(NUM_SEMAPHORES) : 1,
	localparam int PTR_W = $clog2(QUEUE_DEPTH)
) (
	input logic clk,
	input logic wr_en,
	input logic [SEM_W-1:0] wr_sem,
	input logic [PTR_W-1:0] wr_slot,
	input logic [PID_W-1:0] wr_data,
	input logic rd_en,
	input logic [SEM_W-1:0] rd_sem,
	input logic [PTR_W-1:0] rd_slot,
	output logic [PID_W-1:0] rd_data
);

	localparam int DEPTH = NUM_SEMAPHORES * QUEUE_DEPTH;
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [PID_W-1:0] mem [DEPTH];
	logic [PID_W-1:0] rd_data_q;
	logic [AW-1:0] wr_addr;
	logic [AW-1:0] rd_addr;

	assign wr_addr = AW'(wr_sem) * AW'(QUEUE_DEPTH) + AW'(wr_slot);
	assign rd_addr = AW'(rd_sem) * AW'(QUEUE_DEPTH) + AW'(rd_slot);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// pass the word being written straight through when both hit one entry
	always_ff @(posedge clk) begin
		if (rd_en) begin
			if (wr_en && (wr_addr == rd_addr)) begin
				rd_data_q <= wr_data;
			end else begin
				rd_data_q <= mem[rd_addr];
			end
		end
	end

	assign rd_data = rd_data_q;

endmodule

[sv/semaphore_unit_with_wait_queues_top.sv]
// Counting semaphore bank with a first-in first-out wait queue per semaphore.
// Throughput: one command word per cycle while rsp.ready keeps the result
// register draining; the input register and the result register each hold one
// word, and one semaphore is updated per cycle.
// Reset: every count goes to one, every queue empties; wait store contents
// stay undefined until written.
module semaphore_unit_with_wait_queues_top
	import semwq_pkg::*;
#(
	parameter int NUM_SEMAPHORES = NUM_SEMAPHORES_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input logic clk,
	input logic arst_n,
	semwq_cmd_if.sink req,
	semwq_rsp_if.source rsp
);

	localparam int SEM_W = (NUM_SEMAPHORES > 1) ? $clog2(NUM_SEMAPHORES) : 1;
	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	logic vld_s1;
	logic cmd_s1;
	logic [1:0] sem_s1;
	logic [PID_W-1:0] pid_s1;

	logic rsp_vld_q;
	status_t status_q;
	logic [PID_W-1:0] woken_q;

	logic advance;
	logic commit;
	logic accept;

	semwq_res_t res;
	logic [SEM_W-1:0] wr_sem;
	logic [PTR_W-1:0] wr_slot;
	logic [SEM_W-1:0] look_sem;
	logic [PTR_W-1:0] look_slot;
	logic [PID_W-1:0] rd_data;

	assign advance = !rsp_vld_q || rsp.ready;
	assign commit = vld_s1 && advance;
	assign req.ready = !vld_s1 || advance;
	assign accept = req.valid && req.ready;

	semwq_state #(
		.NUM_SEMAPHORES(NUM_SEMAPHORES),
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_state (
		.clk(clk),
		.arst_n(arst_n),
		.commit(commit),
		.command(cmd_s1),
		.mutex_id(sem_s1),
		.look_id(req.mutex_id),
		.res(res),
		.wr_sem(wr_sem),
		.wr_slot(wr_slot),
		.look_sem(look_sem),
		.look_slot(look_slot)
	);

	semwq_store #(
		.NUM_SEMAPHORES(NUM_SEMAPHORES),
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_store (
		.clk(clk),
		.wr_en(commit && res.push),
		.wr_sem(wr_sem),
		.wr_slot(wr_slot),
		.wr_data(pid_s1),
		.rd_en(accept),
		.rd_sem(look_sem),
		.rd_slot(look_slot),
		.rd_data(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			rsp_vld_q <= 1'b0;
		end else begin
			if (req.ready) begin
				vld_s1 <= req.valid;
			end
			if (advance) begin
				rsp_vld_q <= vld_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= req.command;
			sem_s1 <= req.mutex_id;
			pid_s1 <= req.process_id;
		end
		if (commit) begin
			status_q <= res.status;
			woken_q <= res.pop ? rd_data : '0;
		end
	end

	assign rsp.valid = rsp_vld_q;
	assign rsp.status = status_q;
	assign rsp.woken_pid = woken_q;

endmodule

[bench/tb_semaphore_unit_with_wait_queues_top.sv]
module tb_semaphore_unit_with_wait_queues_top;
	import semwq_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int NSEM = NUM_SEMAPHORES_DEF;
	localparam int QD = QUEUE_DEPTH_DEF;
	localparam int RANDOM_WORDS = 1600;

	typedef struct {
		status_t status;
		logic [PID_W-1:0] pid;
	} sem_outcome_t;

	// Tracks counts and wait queues of the bank and checks result words in order.
	class sem_bank_tracker;
		logic [COUNT_W-1:0] count [NSEM];
		logic [PID_W-1:0] waiters [NSEM][QD];
		int head [NSEM];
		int tail [NSEM];
		int fill [NSEM];
		sem_outcome_t due_outcomes [$];
		int failures;

		function new();
			for (int s = 0; s < NSEM; s++) begin
				count[s] = COUNT_RESET;
				head[s] = 0;
				tail[s] = 0;
				fill[s] = 0;
			end
			failures = 0;
		endfunction

		function void report(string what);
			failures++;
			if (failures <= 10)
				$display("%0t mismatch: %s", $realtime, what);
		endfunction

		function void note_command(cmd_t op, logic [1:0] sem, logic [PID_W-1:0] pid);
			sem_outcome_t o;
			o.status = ST_INVALID;
			o.pid = '0;
			if (int'(sem) < NSEM) begin
				if (op == CMD_WAIT) begin
					if (count[sem] != '0) begin
						count[sem] = count[sem] - 1'b1;
						o.status = ST_ACQUIRED;
					end else if (fill[sem] >= QD) begin
						o.status = ST_FULL;
					end else begin
						waiters[sem][tail[sem]] = pid;
						tail[sem] = (tail[sem] + 1) % QD;
						fill[sem]++;
						o.status = ST_BLOCKED;
					end
				end else begin
					if (fill[sem] > 0) begin
						o.pid = waiters[sem][head[sem]];
						head[sem] = (head[sem] + 1) % QD;
						fill[sem]--;
						o.status = ST_WOKE;
					end else if (count[sem] == COUNT_MAX) begin
						o.status = ST_SATURATED;
					end else begin
						count[sem] = count[sem] + 1'b1;
						o.status = ST_RELEASED;
					end
				end
			end
			due_outcomes.push_back(o);
		endfunction

		function void check_result(logic [2:0] status, logic [PID_W-1:0] pid);
			sem_outcome_t o;
			if (due_outcomes.size() == 0) begin
				report($sformatf("unexpected word status=%0d woken_pid=%0d", status, pid));
				return;
			end
			o = due_outcomes.pop_front();
			if (status !== o.status)
				report($sformatf("status expected %0d (%s) got %0d",
					o.status, o.status.name(), status));
			if (pid !== o.pid)
				report($sformatf("woken_pid expected %0d got %0d (status %s)",
					o.pid, pid, o.status.name()));
		endfunction

		function int pending();
			return due_outcomes.size();
		endfunction

		function void close();
			while (due_outcomes.size() != 0) begin
				report($sformatf("no word for expected status %s",
					due_outcomes[0].status.name()));
				void'(due_outcomes.pop_front());
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	semwq_cmd_if req_ch();
	semwq_rsp_if rsp_ch();

	semaphore_unit_with_wait_queues_top #(
		.NUM_SEMAPHORES(NSEM),
		.QUEUE_DEPTH(QD)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	sem_bank_tracker tracker = new();

	int gap_pct;
	int stall_pct;
	int stall_left;
	int words_sent;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("FAIL semaphore_unit_with_wait_queues_top");
		$finish;
	end

	// note inputs first so a result can only match an already-accepted word
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready)
				tracker.note_command(cmd_t'(req_ch.command), req_ch.mutex_id,
					req_ch.process_id);
			if (rsp_ch.valid && rsp_ch.ready)
				tracker.check_result(rsp_ch.status, rsp_ch.woken_pid);
		end
	end

	// result-side backpressure: mostly short stalls, a few long ones
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			rsp_ch.ready <= 1'b0;
		end else if ($urandom_range(99) < stall_pct) begin
			stall_left = ($urandom_range(9) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 2);
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= 1'b1;
		end
	end

	function automatic int pick_gap();
		if ($urandom_range(99) >= gap_pct)
			return 0;
		return ($urandom_range(9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
	endfunction

	task automatic send_word(cmd_t op, logic [1:0] sem, logic [PID_W-1:0] pid);
		int gap;
		gap = pick_gap();
		repeat (gap) begin
			@(negedge clk);
			req_ch.valid <= 1'b0;
		end
		@(negedge clk);
		req_ch.valid <= 1'b1;
		req_ch.command <= op;
		req_ch.mutex_id <= sem;
		req_ch.process_id <= pid;
		do
			@(posedge clk);
		while (!req_ch.ready);
		words_sent++;
	endtask

	// hold the sender until every expected word is back
	task automatic drain();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic run_phase(int len, int wait_pct, int focus, int focus_pct, int bad_pct);
		cmd_t op;
		logic [1:0] sem;
		for (int i = 0; i < len; i++) begin
			op = ($urandom_range(99) < wait_pct) ? CMD_WAIT : CMD_SIGNAL;
			if ($urandom_range(99) < bad_pct)
				sem = 2'(NSEM + $urandom_range(3 - NSEM));
			else if ($urandom_range(99) < focus_pct)
				sem = 2'(focus);
			else
				sem = 2'($urandom_range(NSEM - 1));
			send_word(op, sem, 8'($urandom_range(255)));
		end
	endtask

	initial begin
		int phase;
		int pcts [3];
		pcts = '{15, 50, 85};
		words_sent = 0;
		gap_pct = 0;
		stall_pct = 0;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.command = CMD_WAIT;
		req_ch.mutex_id = '0;
		req_ch.process_id = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: invalid ids, grant, fill a queue to full, wake, release
		gap_pct = 30;
		stall_pct = 20;
		send_word(CMD_WAIT, 2'(NSEM), 8'hFF);
		send_word(CMD_SIGNAL, 2'd3, 8'h00);
		send_word(CMD_WAIT, 2'd0, 8'h00);
		send_word(CMD_WAIT, 2'd0, 8'hFF);
		for (int i = 0; i < QD - 1; i++)
			send_word(CMD_WAIT, 2'd0, 8'(1 << (i % 8)));
		send_word(CMD_WAIT, 2'd0, 8'hA5);
		send_word(CMD_SIGNAL, 2'd0, 8'h5A);
		send_word(CMD_SIGNAL, 2'd1, 8'h00);
		send_word(CMD_WAIT, 2'd2, 8'h80);
		send_word(CMD_SIGNAL, 2'd2, 8'h7F);
		send_word(CMD_SIGNAL, 2'd0, 8'hFF);
		drain();

		words_sent = 0;
		phase = 0;
		while (words_sent < RANDOM_WORDS) begin
			case ($urandom_range(3))
				0: begin
					gap_pct = 0;
					stall_pct = 0;
				end
				1: begin
					gap_pct = 20;
					stall_pct = 0;
				end
				2: begin
					gap_pct = 0;
					stall_pct = 25;
				end
				default: begin
					gap_pct = 30;
					stall_pct = 30;
				end
			endcase
			if (phase == 3) begin
				// push one count to the top so it saturates
				run_phase(300, 2, $urandom_range(NSEM - 1), 97, 1);
				drain();
			end else begin
				run_phase($urandom_range(40, 160), pcts[$urandom_range(2)],
					$urandom_range(NSEM - 1), $urandom_range(30, 90), 5);
			end
			phase++;
		end

		drain();
		repeat (10) @(posedge clk);
		tracker.close();
		if (tracker.failures == 0)
			$display("PASS semaphore_unit_with_wait_queues_top");
		else
			$display("FAIL semaphore_unit_with_wait_queues_top");
		$finish;
	end

endmodule
